>>> rtl/sum_tree_weighted_sampler_defines.svh
// Assertion macros shared by the sampler RTL.
`ifndef SUM_TREE_WEIGHTED_SAMPLER_DEFINES_SVH
`define SUM_TREE_WEIGHTED_SAMPLER_DEFINES_SVH

`ifndef ASSERT_OFF
`define STS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define STS_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STS_ASSERT(lbl, clk, rst, prop, msg)
`define STS_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/sts_pkg.sv
package sts_pkg;

  localparam int SUM_W            = 42;
  localparam int LEAF_COUNT_W     = 11;
  localparam int KIND_W           = 2;
  localparam int APB_ADDR_W       = 3;
  localparam int APB_DATA_W       = 32;

  localparam logic [LEAF_COUNT_W-1:0] LEAF_COUNT_RESET = 11'd1024;

  // register index, taken from paddr[2]
  localparam logic REG_LEAF_COUNT = 1'b0;

  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REBUILD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd3;

  typedef struct packed {
    logic clr_step;   // clearing pass: zero one entry of the sum RAM and, within LEAVES, of the leaf RAM
    logic load;       // write the leaf RAM from the input beat
    logic capture;    // latch target, start descent at the root
    logic desc_step;  // one tree level of the descent
    logic rm_latch;   // take the leaf weight, update live sum
    logic rm_step;    // one ancestor of the removal walk
    logic rb_start;   // rebuild: first leaf
    logic rb_read;    // rebuild: leaf RAM read at the sweep index
    logic rb_latch;   // rebuild: take the leaf value as carry
    logic rb_step;    // rebuild: one level of the climb
    logic emit;       // load the result registers
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic lvl_last;
    logic rb_stop;
    logic rb_last;
  } status_t;

endpackage

>>> rtl/sum_tree_weighted_sampler.sv
// Weighted sampler over a binary sum tree of up to LEAVES weights. A load
// leaves busy low and the next beat may follow at once. A sample holds busy
// through a descent of clog2(LEAVES) levels (10 by default), and its result
// strobes on done in the first cycle with busy low, so each sample finishes
// before the next is taken; the descent reads one left sum per level from the
// sum RAM. Sample-and-remove adds a leaf read and a walk down the path from
// the root, one ancestor per cycle, rewriting the left sum of each ancestor
// whose left subtree holds the leaf. A rebuild sweeps every leaf of the span
// (LEAVES rounded up to a power of two) with a leaf read, a latch and a climb
// of one level per cycle for each leaf. After reset the block stays busy
// while both RAMs are cleared; leaf_count may be written during that time.
// done lasts one cycle and cannot be held off.
module sum_tree_weighted_sampler #(
  parameter int LEAVES      = 1024,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [sts_pkg::KIND_W-1:0]           kind,
  input  logic [9:0]                           leaf_index,
  input  logic [31:0]                          weight,
  input  logic [sts_pkg::SUM_W-1:0]            target,
  output logic                                 done,
  output logic [sts_pkg::LEAF_COUNT_W-1:0]     picked_index,
  output logic [sts_pkg::SUM_W-1:0]            remaining_sum,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sts_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [sts_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [sts_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  logic [sts_pkg::LEAF_COUNT_W-1:0] leaf_count;
  sts_pkg::cmd_t                    cmd;
  sts_pkg::status_t                 status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= sts_pkg::LEAF_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == sts_pkg::REG_LEAF_COUNT) begin
      leaf_count <= pwdata[sts_pkg::LEAF_COUNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == sts_pkg::REG_LEAF_COUNT) ?
                  sts_pkg::APB_DATA_W'(leaf_count) : '0;

  sts_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  sts_dp #(
    .LEAVES      (LEAVES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .leaf_count    (leaf_count),
    .leaf_index    (leaf_index),
    .weight        (weight),
    .target        (target),
    .picked_index  (picked_index),
    .remaining_sum (remaining_sum),
    .done          (done)
  );

endmodule

>>> rtl/sts_ram.sv
module sts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sts_ctrl.sv
`include "sum_tree_weighted_sampler_defines.svh"

module sts_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sts_pkg::KIND_W-1:0] kind,
  input  sts_pkg::status_t           status,
  output logic                       busy,
  output sts_pkg::cmd_t              cmd
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DESC   = 4'd2;
  localparam logic [3:0] ST_RM_RD  = 4'd3;
  localparam logic [3:0] ST_RM_LAT = 4'd4;
  localparam logic [3:0] ST_RM_UP  = 4'd5;
  localparam logic [3:0] ST_FIN    = 4'd6;
  localparam logic [3:0] ST_RB_RD  = 4'd7;
  localparam logic [3:0] ST_RB_LAT = 4'd8;
  localparam logic [3:0] ST_RB_UP  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       remove;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      remove <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && start) begin
        remove <= (kind == sts_pkg::KIND_REMOVE);
      end
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (kind)
            sts_pkg::KIND_LOAD: begin
              cmd.load = 1'b1;
            end
            sts_pkg::KIND_REBUILD: begin
              cmd.rb_start = 1'b1;
              state_next   = ST_RB_RD;
            end
            sts_pkg::KIND_SAMPLE, sts_pkg::KIND_REMOVE: begin
              cmd.capture = 1'b1;
              state_next  = ST_DESC;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DESC: begin
        cmd.desc_step = 1'b1;
        if (status.lvl_last) begin
          state_next = remove ? ST_RM_RD : ST_FIN;
        end
      end
      ST_RM_RD: begin
        state_next = ST_RM_LAT;
      end
      ST_RM_LAT: begin
        cmd.rm_latch = 1'b1;
        state_next   = ST_RM_UP;
      end
      ST_RM_UP: begin
        cmd.rm_step = 1'b1;
        if (status.lvl_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RB_RD: begin
        cmd.rb_read = 1'b1;
        state_next  = ST_RB_LAT;
      end
      ST_RB_LAT: begin
        cmd.rb_latch = 1'b1;
        state_next   = ST_RB_UP;
      end
      ST_RB_UP: begin
        cmd.rb_step = 1'b1;
        if (status.rb_stop) begin
          state_next = status.rb_last ? ST_IDLE : ST_RB_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  `STS_ASSERT_NORST(a_clear_after_reset, clk, rst |=> busy, "no clearing pass after reset")
  `STS_ASSERT(a_work_goes_busy, clk, rst,
    (start && !busy && kind != sts_pkg::KIND_LOAD) |=> busy, "accepted item left ctrl idle")

endmodule

>>> rtl/sts_dp.sv
`include "sum_tree_weighted_sampler_defines.svh"

module sts_dp #(
  parameter int LEAVES      = 1024,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sts_pkg::cmd_t                    cmd,
  output sts_pkg::status_t                 status,
  input  logic [sts_pkg::LEAF_COUNT_W-1:0] leaf_count,
  input  logic [9:0]                       leaf_index,
  input  logic [31:0]                      weight,
  input  logic [sts_pkg::SUM_W-1:0]        target,
  output logic [sts_pkg::LEAF_COUNT_W-1:0] picked_index,
  output logic [sts_pkg::SUM_W-1:0]        remaining_sum,
  output logic                             done
);

  localparam int LEVELS = $clog2(LEAVES);
  localparam int SPAN   = 1 << LEVELS;
  localparam int NW     = LEVELS + 1;
  localparam int LVW    = $clog2(LEVELS + 1);
  localparam int LIW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int SW     = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32;
  localparam int CW     = (NW > sts_pkg::LEAF_COUNT_W) ? NW : sts_pkg::LEAF_COUNT_W;
  localparam int SUMW   = sts_pkg::SUM_W;

  function automatic logic [SUMW-1:0] sat_add(input logic [SUMW-1:0] a,
                                               input logic [SUMW-1:0] b);
    logic [SUMW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUMW] ? {SUMW{1'b1}} : s[SUMW-1:0];
  endfunction

  function automatic logic [SUMW-1:0] sat_sub(input logic [SUMW-1:0] a,
                                               input logic [SUMW-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  // control registers
  logic [LEVELS-1:0] clr;
  logic [SUMW-1:0]   live_sum;
  // working registers
  logic [NW-1:0]     node;
  logic [SUMW-1:0]   d;
  logic [LVW-1:0]    lvl;
  logic [SUMW-1:0]   path_ls [LEVELS];
  logic [SUMW-1:0]   pend [LEVELS];
  logic [SUMW-1:0]   carry;
  logic [SUMW-1:0]   w;
  logic [LEVELS-1:0] rb_i;
  logic [sts_pkg::LEAF_COUNT_W-1:0] picked_q;
  logic [SUMW-1:0]   rem_q;

  logic [SUMW-1:0]   ls_q;
  logic [SW-1:0]     leaf_q;
  logic              s_we;
  logic [LEVELS-1:0] s_waddr;
  logic [SUMW-1:0]   s_wdata;
  logic [LEVELS-1:0] s_raddr;
  logic              l_we;
  logic [LEVELS-1:0] l_waddr;
  logic [SW-1:0]     l_wdata;
  logic [LEVELS-1:0] l_raddr;

  logic [LEVELS-1:0] leaf;
  logic [CW-1:0]     eff;
  logic              leaf_live;
  logic              rb_live;
  logic              go_left;
  logic [NW-1:0]     next_node;
  logic [SUMW-1:0]   leaf_ext;
  logic [SUMW-1:0]   w_now;
  logic [NW-1:0]     rb_node;
  logic [NW-1:0]     rb_parent;
  logic              rb_at_root;
  logic [NW-1:0]     rm_child;
  logic [NW-1:0]     rm_parent;
  logic [LIW-1:0]    lv_idx;
  logic [SUMW-1:0]   pend_q;
  logic [SUMW-1:0]   path_q;
  logic              load_ok;
  logic              clr_in_leaves;
  logic [CW-1:0]     pick_full;

  sts_ram #(.WIDTH(SUMW), .DEPTH(SPAN)) u_sum_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (ls_q)
  );

  sts_ram #(.WIDTH(SW), .DEPTH(LEAVES)) u_leaf_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (leaf_q)
  );

  assign leaf      = node[LEVELS-1:0];
  assign eff       = (CW'(leaf_count) > CW'(LEAVES)) ? CW'(LEAVES) : CW'(leaf_count);
  assign leaf_live = CW'(leaf) < eff;
  assign rb_live   = CW'(rb_i) < eff;
  assign go_left   = d <= ls_q;
  assign next_node = {node[LEVELS-1:0], ~go_left};
  assign leaf_ext  = SUMW'(leaf_q);
  assign w_now     = leaf_live ? leaf_ext : '0;
  assign lv_idx    = lvl[LIW-1:0];
  assign pend_q    = pend[lv_idx];
  assign path_q    = path_ls[lv_idx];

  // rebuild climb: node of leaf rb_i at height lvl, a right child unless bit is 0
  assign rb_node    = {1'b1, rb_i} >> lvl;
  assign rb_parent  = rb_node >> 1;
  assign rb_at_root = (lvl == LVW'(LEVELS));

  // removal walk: path node at depth lvl+1 and its parent
  assign rm_child  = node >> (LVW'(LEVELS - 1) - lvl);
  assign rm_parent = rm_child >> 1;

  assign load_ok       = 32'(leaf_index) < 32'(LEAVES);
  assign clr_in_leaves = {1'b0, clr} < NW'(LEAVES);
  assign pick_full     = leaf_live ? CW'(leaf) : eff;

  always_comb begin
    s_we    = 1'b0;
    s_waddr = clr;
    s_wdata = '0;
    if (cmd.clr_step) begin
      s_we = 1'b1;
    end else if (cmd.rb_step && !(rb_at_root || !rb_node[0])) begin
      s_we    = 1'b1;
      s_waddr = rb_parent[LEVELS-1:0];
      s_wdata = pend_q;
    end else if (cmd.rm_step && !rm_child[0]) begin
      s_we    = 1'b1;
      s_waddr = rm_parent[LEVELS-1:0];
      s_wdata = sat_sub(path_q, w);
    end
  end

  // idle reads the root so a descent starts with its left sum in hand
  assign s_raddr = cmd.desc_step ? next_node[LEVELS-1:0] : LEVELS'(1);

  assign l_we    = cmd.clr_step ? clr_in_leaves : (cmd.load && load_ok);
  assign l_waddr = cmd.clr_step ? clr : LEVELS'(leaf_index);
  assign l_wdata = cmd.clr_step ? '0 : weight[SW-1:0];
  assign l_raddr = cmd.rb_read ? rb_i : leaf;

  assign status.clr_last = &clr;
  assign status.lvl_last = (lvl == LVW'(LEVELS - 1));
  assign status.rb_stop  = rb_at_root || !rb_node[0];
  assign status.rb_last  = &rb_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr      <= '0;
      live_sum <= '0;
      done     <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cmd.clr_step) begin
        clr <= clr + 1'b1;
      end
      if (cmd.rm_latch) begin
        live_sum <= sat_sub(live_sum, w_now);
      end
      if (cmd.rb_step && rb_at_root) begin
        live_sum <= carry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      node <= NW'(1);
      d    <= target;
      lvl  <= '0;
    end
    if (cmd.desc_step) begin
      path_ls[lv_idx] <= ls_q;
      node            <= next_node;
      if (!go_left) begin
        d <= d - ls_q;
      end
      lvl <= lvl + 1'b1;
    end
    if (cmd.rm_latch) begin
      w   <= w_now;
      lvl <= '0;
    end
    if (cmd.rm_step) begin
      lvl <= lvl + 1'b1;
    end
    if (cmd.rb_start) begin
      rb_i <= '0;
    end
    if (cmd.rb_latch) begin
      carry <= rb_live ? leaf_ext : '0;
      lvl   <= '0;
    end
    if (cmd.rb_step) begin
      if (rb_at_root || !rb_node[0]) begin
        rb_i <= rb_i + 1'b1;
        if (!rb_at_root) begin
          pend[lv_idx] <= carry;
        end
      end else begin
        carry <= sat_add(pend_q, carry);
        lvl   <= lvl + 1'b1;
      end
    end
    if (cmd.emit) begin
      picked_q <= pick_full[sts_pkg::LEAF_COUNT_W-1:0];
      rem_q    <= live_sum;
    end
  end

  assign picked_index  = picked_q;
  assign remaining_sum = rem_q;

  `STS_ASSERT(a_single_beat, clk, rst, done |=> !done, "result strobe held two cycles")
  `STS_ASSERT(a_live_only_rises_on_rebuild, clk, rst,
    !cmd.rb_step |=> live_sum <= $past(live_sum), "live sum grew outside a rebuild")

endmodule
